// File: sv/pwrfe_pkg.sv
// shared types and constants of the pulse width radio frame encoder
package pwrfe_pkg;

   localparam int MAX_BYTES = 256;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int POS_W     = $clog2(MAX_BYTES + 5);

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BYTES);

   localparam logic [7:0] PREAMBLE_RESET = 8'd50;

   // command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // frame phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_PRE   = 3'd1;
   localparam logic [2:0] PH_START = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_STOP  = 3'd4;

   // trailer bytes after the payload
   localparam logic [1:0] TRL_SUM_HI = 2'd0;
   localparam logic [1:0] TRL_SUM_LO = 2'd1;
   localparam logic [1:0] TRL_INV_HI = 2'd2;

   localparam logic [15:0] HI_MASK = 16'hFF00;
   localparam logic [15:0] LO_MASK = 16'h00FF;
   localparam logic [15:0] SUM_ZERO = 16'h0000;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic done_res;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } buf_ctl_type;

endpackage

// File: sv/pwrfe_buffer.sv
// packet byte buffer, one write and one registered read port
module pwrfe_buffer
   import pwrfe_pkg::*;
(
   input  logic        clock,
   input  buf_ctl_type buf_ctl,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [MAX_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (buf_ctl.wr_en) begin
         mem[buf_ctl.wr_addr] <= buf_ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_ctl.rd_en) begin
         rd_data_ff <= mem[buf_ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pulse_width_radio_frame_encoder.sv
// top level of the pulse width radio frame encoder: frame sequencer around the byte buffer
//
//   channel | ports                          | direction | transaction
//   --------+--------------------------------+-----------+--------------------------------
//   req     | req_valid, req_stall, req_payload | in     | one command: load, start or tick
//   rsp     | rsp_valid, rsp_stall, rsp_payload | out    | one status word per command
//   csr     | csr_write_en, csr_write_data   | in        | preamble pair count
//
// on accept, a command issues a buffer read at the current byte position; the
// command stage then uses the read data and updates the frame state
// a new command is taken only once the previous one has left the command stage
// results sit in an output register, so the next command is taken while a result waits
// a stalled result holds the command stage until the output register frees up
// synchronous reset clears the frame state; buffer contents stay undefined until loaded
module pulse_width_radio_frame_encoder
   import pwrfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   // command stage
   logic        stage_ff;
   logic        stage_in;
   req_type     cmd_ff;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   // frame state
   logic [7:0]       preamble_ff;
   logic [CNT_W-1:0] byte_count_ff,  byte_count_in;
   logic [2:0]       phase_ff,       phase_in;
   logic [8:0]       period_ff,      period_in;
   logic [2:0]       bit_pos_ff,     bit_pos_in;
   logic [POS_W-1:0] byte_pos_ff,    byte_pos_in;
   logic [15:0]      sum_ff,         sum_in;
   logic [1:0]       half_ff,        half_in;

   logic        req_fire;
   logic        exec;
   logic        busy;
   logic        in_payload;
   logic [1:0]  trailer_idx;
   logic [7:0]  cur_byte;
   logic        cur_bit;
   logic [7:0]  rd_data;
   logic [9:0]  period_next;
   logic [9:0]  pre_limit;
   logic [POS_W:0] pos_next;
   logic [POS_W:0] pos_limit;
   buf_ctl_type buf_ctl;

   assign req_stall = stage_ff;
   assign req_fire  = req_valid && !stage_ff;
   // command runs once the output register is empty or being drained
   assign exec      = stage_ff && (!rsp_valid_ff || !rsp_stall);

   assign busy        = (phase_ff != PH_IDLE);
   assign in_payload  = ({1'b0, byte_pos_ff} < {{(POS_W + 1 - CNT_W){1'b0}}, byte_count_ff});
   assign trailer_idx = 2'(byte_pos_ff - POS_W'(byte_count_ff));
   assign period_next = {1'b0, period_ff} + 10'd1;
   assign pre_limit   = {1'b0, preamble_ff, 1'b0};
   assign pos_next    = {1'b0, byte_pos_ff} + (POS_W + 1)'(1);
   assign pos_limit   = (POS_W + 1)'(byte_count_ff) + (POS_W + 1)'(4);

   // byte being sent: buffer data for payload, then checksum trailer
   always_comb begin
      if (in_payload) begin
         cur_byte = rd_data;
      end else begin
         case (trailer_idx)
            TRL_SUM_HI: cur_byte = 8'((sum_ff & HI_MASK) >> 8);
            TRL_SUM_LO: cur_byte = 8'(sum_ff & LO_MASK);
            TRL_INV_HI: cur_byte = 8'(((~sum_ff) & HI_MASK) >> 8);
            default:    cur_byte = 8'((~sum_ff) & LO_MASK);
         endcase
      end
   end

   assign cur_bit = cur_byte[bit_pos_ff];

   // buffer access: read at the current byte position on accept, write on load
   always_comb begin
      buf_ctl.rd_en   = req_fire;
      buf_ctl.rd_addr = byte_pos_ff[ADDR_W-1:0];
      buf_ctl.wr_en   = exec && (cmd_ff.cmd == CMD_LOAD) && !busy
                        && (byte_count_ff != MAX_COUNT);
      buf_ctl.wr_addr = byte_count_ff[ADDR_W-1:0];
      buf_ctl.wr_data = cmd_ff.byte_value;
   end

   pwrfe_buffer u_buffer (
      .clock   (clock),
      .buf_ctl (buf_ctl),
      .rd_data (rd_data)
   );

   // frame sequencer
   always_comb begin
      byte_count_in = byte_count_ff;
      phase_in      = phase_ff;
      period_in     = period_ff;
      bit_pos_in    = bit_pos_ff;
      byte_pos_in   = byte_pos_ff;
      sum_in        = sum_ff;
      half_in       = half_ff;
      rsp_in.line_level = 1'b0;
      rsp_in.busy_res   = busy;
      rsp_in.done_res   = 1'b0;
      rsp_in.rejected   = 1'b0;

      case (cmd_ff.cmd)
         CMD_LOAD: begin
            if (busy || (byte_count_ff == MAX_COUNT)) begin
               rsp_in.rejected = 1'b1;
            end else begin
               byte_count_in = byte_count_ff + CNT_W'(1);
            end
         end
         CMD_START: begin
            if (busy) begin
               rsp_in.rejected = 1'b1;
            end else begin
               phase_in    = (preamble_ff == 8'd0) ? PH_START : PH_PRE;
               period_in   = 9'd0;
               bit_pos_in  = 3'd0;
               byte_pos_in = '0;
               half_in     = 2'd0;
               sum_in      = SUM_ZERO;
            end
         end
         CMD_TICK: begin
            unique case (phase_ff)
               PH_PRE: begin
                  rsp_in.line_level = !period_ff[0];
                  period_in = period_next[8:0];
                  if (period_next >= pre_limit) begin
                     phase_in  = PH_START;
                     period_in = 9'd0;
                  end
               end
               PH_START: begin
                  rsp_in.line_level = 1'b1;
                  period_in = period_next[8:0];
                  if (period_next >= 10'd3) begin
                     phase_in  = PH_DATA;
                     period_in = 9'd0;
                  end
               end
               PH_DATA: begin
                  // low half, high half, and an extra high half for a one
                  rsp_in.line_level = (half_ff != 2'd0);
                  if (half_ff == 2'd0) begin
                     half_in = 2'd1;
                  end else if ((half_ff == 2'd1) && cur_bit) begin
                     half_in = 2'd2;
                  end else begin
                     half_in = 2'd0;
                     if (bit_pos_ff != 3'd7) begin
                        bit_pos_in = bit_pos_ff + 3'd1;
                     end else begin
                        bit_pos_in  = 3'd0;
                        byte_pos_in = pos_next[POS_W-1:0];
                        if (in_payload) begin
                           sum_in = sum_ff + {8'd0, rd_data};
                        end
                        if (pos_next >= pos_limit) begin
                           phase_in  = PH_STOP;
                           period_in = 9'd0;
                        end
                     end
                  end
               end
               PH_STOP: begin
                  rsp_in.line_level = (period_ff != 9'd0);
                  period_in = period_next[8:0];
                  if (period_next >= 10'd5) begin
                     rsp_in.done_res = 1'b1;
                     phase_in        = PH_IDLE;
                     period_in       = 9'd0;
                     byte_count_in   = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stage_in = stage_ff;
      if (req_fire) begin
         stage_in = 1'b1;
      end else if (exec) begin
         stage_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         preamble_ff   <= PREAMBLE_RESET;
         byte_count_ff <= '0;
         phase_ff      <= PH_IDLE;
         period_ff     <= 9'd0;
         bit_pos_ff    <= 3'd0;
         byte_pos_ff   <= '0;
         sum_ff        <= SUM_ZERO;
         half_ff       <= 2'd0;
      end else begin
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            preamble_ff <= csr_write_data;
         end
         if (exec) begin
            byte_count_ff <= byte_count_in;
            phase_ff      <= phase_in;
            period_ff     <= period_in;
            bit_pos_ff    <= bit_pos_in;
            byte_pos_ff   <= byte_pos_in;
            sum_ff        <= sum_in;
            half_ff       <= half_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_payload;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: tb/pulse_width_radio_frame_encoder_tb.sv
// self-checking testbench of the pulse width radio frame encoder
`timescale 1ns / 100ps

module pulse_width_radio_frame_encoder_tb;
   import pwrfe_pkg::*;

   // command code the block leaves alone
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // quiet cycles after the last status
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 60;
   // start pulse, stop pulse and the four trailer bytes
   // (sum and inverse always carry sixteen ones between them)
   localparam int FRAME_FIXED_TICKS = 3 + 5 + 4 * 16 + 16;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_write_en = 1'b0;
   logic [7:0] csr_write_data = '0;

   pulse_width_radio_frame_encoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // commands waiting to be driven, and status words still to come back
   req_type cmd_queue[$];
   rsp_type awaited_status[$];
   logic    req_taken = 1'b0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      mismatch_count = 0;

   // ------------------------------------------------------------------
   // frame predictor: shadow of the encoder state, advanced per command
   // ------------------------------------------------------------------
   logic [7:0]       shadow_buf [MAX_BYTES];
   logic [CNT_W-1:0] loaded_count;
   logic [2:0]       tx_phase;
   logic [8:0]       period_cnt;
   logic [2:0]       bit_idx;
   logic [POS_W-1:0] byte_idx;
   logic [15:0]      running_sum;
   logic [1:0]       half_idx;
   logic [7:0]       pair_setting;

   // byte on the air: payload first, then sum high/low and its inverse high/low
   function automatic logic [7:0] outgoing_byte();
      logic [POS_W-1:0] trailer;
      if (byte_idx < loaded_count) return shadow_buf[byte_idx[ADDR_W-1:0]];
      trailer = byte_idx - loaded_count;
      case (trailer[1:0])
         TRL_SUM_HI: return running_sum[15:8];
         TRL_SUM_LO: return running_sum[7:0];
         TRL_INV_HI: return ~running_sum[15:8];
         default:    return ~running_sum[7:0];
      endcase
   endfunction

   // one bit fully sent: step bit, then byte, then into the stop pulse
   function automatic void advance_bit();
      half_idx = 2'd0;
      if (bit_idx < 3'd7) begin
         bit_idx++;
         return;
      end
      bit_idx = 3'd0;
      if (byte_idx < loaded_count)
         running_sum = running_sum + 16'(shadow_buf[byte_idx[ADDR_W-1:0]]);
      byte_idx++;
      if (byte_idx >= loaded_count + 4) begin
         tx_phase   = PH_STOP;
         period_cnt = '0;
      end
   endfunction

   function automatic rsp_type encode_step(req_type cmd_in);
      rsp_type    status;
      logic [7:0] cur;
      status          = '0;
      status.busy_res = (tx_phase != PH_IDLE);
      case (cmd_in.cmd)
         CMD_LOAD: begin
            if (status.busy_res || loaded_count >= MAX_COUNT) begin
               status.rejected = 1'b1;
            end else begin
               shadow_buf[loaded_count[ADDR_W-1:0]] = cmd_in.byte_value;
               loaded_count++;
            end
         end
         CMD_START: begin
            if (status.busy_res) begin
               status.rejected = 1'b1;
            end else begin
               tx_phase    = (pair_setting == 8'd0) ? PH_START : PH_PRE;
               period_cnt  = '0;
               bit_idx     = '0;
               byte_idx    = '0;
               half_idx    = '0;
               running_sum = SUM_ZERO;
            end
         end
         CMD_TICK: begin
            if (status.busy_res) begin
               case (tx_phase)
                  PH_PRE: begin
                     status.line_level = ~period_cnt[0];
                     period_cnt++;
                     if (period_cnt >= 2 * pair_setting) begin
                        tx_phase   = PH_START;
                        period_cnt = '0;
                     end
                  end
                  PH_START: begin
                     status.line_level = 1'b1;
                     period_cnt++;
                     if (period_cnt >= 3) begin
                        tx_phase   = PH_DATA;
                        period_cnt = '0;
                     end
                  end
                  PH_DATA: begin
                     cur = outgoing_byte();
                     if (half_idx == 2'd0) begin
                        status.line_level = 1'b0;
                        half_idx = 2'd1;
                     end else if (half_idx == 2'd1) begin
                        status.line_level = 1'b1;
                        if (cur[bit_idx]) half_idx = 2'd2;
                        else advance_bit();
                     end else begin
                        status.line_level = 1'b1;
                        advance_bit();
                     end
                  end
                  default: begin
                     // stop pulse: one low period, four high
                     status.line_level = (period_cnt != 0);
                     period_cnt++;
                     if (period_cnt >= 5) begin
                        status.done_res = 1'b1;
                        tx_phase     = PH_IDLE;
                        period_cnt   = '0;
                        loaded_count = '0;
                     end
                  end
               endcase
            end
         end
         default: ;  // unused code changes nothing
      endcase
      return status;
   endfunction

   // predict on every accepted command, check every accepted status word
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         loaded_count = '0;
         tx_phase     = PH_IDLE;
         period_cnt   = '0;
         bit_idx      = '0;
         byte_idx     = '0;
         running_sum  = SUM_ZERO;
         half_idx     = '0;
         pair_setting = PREAMBLE_RESET;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_write_en) pair_setting = csr_write_data;
         if (req_valid && !req_stall) awaited_status.push_back(encode_step(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               mismatch_count++;
               $display("%0t: status with nothing outstanding, expected none, got %p",
                        $time, rsp_payload);
            end else begin
               want = awaited_status.pop_front();
               if (rsp_payload.line_level !== want.line_level ||
                   rsp_payload.busy_res   !== want.busy_res ||
                   rsp_payload.done_res   !== want.done_res ||
                   rsp_payload.rejected   !== want.rejected) begin
                  mismatch_count++;
                  $display("%0t: status mismatch, expected %p, got %p",
                           $time, want, rsp_payload);
               end
            end
         end
      end
   end

   // command driver: a new transaction only once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= cmd_queue.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------
   // stimulus: the generator keeps its own view of the staged packet
   // so it knows how many ticks a frame needs
   // ------------------------------------------------------------------
   logic [7:0] staged_bytes[$];
   int         preamble_now = int'(PREAMBLE_RESET);
   int         counted_items = 0;

   task automatic push_cmd(logic [1:0] code, logic [7:0] value);
      req_type item;
      item.cmd        = code;
      item.byte_value = value;
      cmd_queue.push_back(item);
   endtask

   // load while idle; past capacity the load is rejected and not staged
   task automatic stage_load(logic [7:0] value);
      push_cmd(CMD_LOAD, value);
      if (staged_bytes.size() < MAX_BYTES) staged_bytes.push_back(value);
      counted_items++;
   endtask

   function automatic int frame_length();
      int ticks;
      ticks = 2 * preamble_now + FRAME_FIXED_TICKS;
      foreach (staged_bytes[i]) ticks += 16 + $countones(staged_bytes[i]);
      return ticks;
   endfunction

   // ticks of a running frame, with rejected loads/starts and unused codes mixed in
   task automatic run_ticks(int count, int noise_pct);
      repeat (count) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0: push_cmd(CMD_LOAD, 8'($urandom_range(255)));
               1: push_cmd(CMD_START, 8'($urandom_range(255)));
               default: push_cmd(CMD_UNUSED, 8'($urandom_range(255)));
            endcase
            counted_items++;
         end
         push_cmd(CMD_TICK, 8'($urandom_range(255)));
         counted_items++;
      end
   endtask

   task automatic send_frame(int noise_pct);
      int ticks;
      ticks = frame_length();
      push_cmd(CMD_START, 8'($urandom_range(255)));
      counted_items++;
      staged_bytes.delete();
      run_ticks(ticks, noise_pct);
   endtask

   // hold the sender until every status has come back and the pipe is quiet
   task automatic drain();
      do begin
         @(posedge clock);
         #2;
      end while (cmd_queue.size() != 0 || req_valid || awaited_status.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pairs(logic [7:0] pairs);
      drain();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= pairs;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      preamble_now = int'(pairs);
   endtask

   task automatic set_flow(flow_mode_type mode);
      case (mode)
         FLOW_FREE:           begin send_idle_pct = 0;  stall_pct = 0;  end
         FLOW_SENDER_IDLE:    begin send_idle_pct = 64; stall_pct = 0;  end
         FLOW_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 64; end
         default:             begin send_idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   // mostly complete short frames, some retuning, the rest noise and partial packets
   task automatic random_sequence();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 75) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
         repeat (len) stage_load(8'($urandom_range(255)));
         send_frame(6);
         if ($urandom_range(3) == 0) push_cmd(CMD_TICK, 8'($urandom_range(255)));
      end else if (pick < 85) begin
         write_pairs(8'($urandom_range(0, 5)));
      end else begin
         case ($urandom_range(2))
            0: push_cmd(CMD_UNUSED, 8'($urandom_range(255)));
            1: push_cmd(CMD_TICK, 8'($urandom_range(255)));
            default: if (staged_bytes.size() < 32) stage_load(8'($urandom_range(255)));
         endcase
      end
   endtask

   initial begin
      int target;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no idling: one frame at the reset preamble count
      set_flow(FLOW_FREE);
      push_cmd(CMD_TICK, 8'h00);      // tick while idle is ignored
      push_cmd(CMD_UNUSED, 8'hFF);
      stage_load(8'h81);
      send_frame(5);                  // preamble count still at its reset value

      // sender idle: longest preamble cut short by a write while the frame is running
      write_pairs(8'd255);
      set_flow(FLOW_SENDER_IDLE);
      stage_load(8'h5A);
      push_cmd(CMD_START, 8'h00);
      counted_items++;
      run_ticks(5, 0);
      write_pairs(8'd1);
      run_ticks(1 + frame_length() - 2 * preamble_now, 0);
      staged_bytes.delete();
      push_cmd(CMD_TICK, 8'hA5);

      // receiver stalling: no preamble at first, then random frames and noise
      write_pairs(8'd0);
      set_flow(FLOW_RECEIVER_STALL);
      target = counted_items + ITEMS_PER_PHASE;
      while (counted_items < target) random_sequence();

      // both idle: full buffer, the loads past capacity get rejected
      write_pairs(8'd3);
      set_flow(FLOW_BOTH);
      repeat (MAX_BYTES) stage_load(8'($urandom_range(255)));
      stage_load(8'hC3);
      stage_load(8'h3C);
      push_cmd(CMD_START, 8'h00);
      counted_items++;
      run_ticks(8, 30);

      drain();
      if (mismatch_count == 0) begin
         $display("[pulse_width_radio_frame_encoder] OK");
      end else begin
         $display("[pulse_width_radio_frame_encoder] ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest passing run
   initial begin
      #2_000_000;
      $display("[pulse_width_radio_frame_encoder] ERROR");
      $finish;
   end

endmodule

// File: pulse_width_radio_frame_encoder.f
sv/pwrfe_pkg.sv
sv/pwrfe_buffer.sv
sv/pulse_width_radio_frame_encoder.sv
tb/pulse_width_radio_frame_encoder_tb.sv
